### rtl/ufbd_pkg.sv
// Package for the UART fractional baud divider core.
// Holds the stage payload type, config register indices and widths.
// No dependencies.
package ufbd_pkg;

    localparam int SysClkW   = 29;
    localparam int BaudW     = 24;
    localparam int DenW      = 28;
    localparam int QuoW      = 9;
    localparam int FracW     = 7;
    localparam int IntW      = 8;
    localparam int CfgIdxW   = 2;

    localparam int NumIntCells  = 9;
    localparam int NumFracCells = 8;

    localparam logic [SysClkW-1:0] SysClkReset = 29'd8000000;
    localparam logic [FracW-1:0]   FracOff     = 7'h7F;

    localparam logic [CfgIdxW-1:0] CfgSysClk   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgPrescale = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgHalfOvs  = 2'd2;

    typedef struct packed {
        logic [SysClkW-1:0] rem;    // partial remainder
        logic [SysClkW-1:0] dvs;    // divisor
        logic [QuoW-1:0]    nbits;  // dividend bits still to shift in, msb first
        logic [QuoW-1:0]    quo;    // quotient accumulator
        logic [SysClkW-1:0] pclk;   // peripheral clock
        logic [QuoW-1:0]    qint;   // integer quotient, kept for the fraction pass
        logic               err;
        logic               exact;
    } stage_t;

endpackage

### rtl/uart_fractional_baud_divider_core.sv
// Top level of the UART fractional baud divider: config registers, the cell
// chain and the output register. Depends on ufbd_pkg, ufbd_prep, ufbd_cell, ufbd_swap.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------------
//   in      | in        | in_valid / in_stall | baud_rate
//   out     | out       | out_valid/out_stall | status, fraction_enable, divider_fraction,
//           |           |                     | divider_integer
//   cfg     | in        | cfg_write           | cfg_index, cfg_data
//
// One beat per cycle while out is not stalled; stages in order: entry stage, 9 integer
// cells, turn-around stage, 8 fraction cells, output register.
// Each stage holds its beat until the next one frees, so bubbles are squeezed out
// and a stall on out fills the chain before in_stall rises.
// Reset empties the chain and loads the config defaults.
module uart_fractional_baud_divider_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ufbd_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ufbd_pkg::SysClkW-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ufbd_pkg::BaudW-1:0]     baud_rate,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           status,
    output logic                           fraction_enable,
    output logic [ufbd_pkg::FracW-1:0]     divider_fraction,
    output logic [ufbd_pkg::IntW-1:0]      divider_integer
);
    import ufbd_pkg::*;

    localparam int NumCells = NumIntCells + NumFracCells;

    logic [SysClkW-1:0] sys_clk_reg;
    logic [1:0]         prescale_reg;
    logic               half_ovs_reg;

    logic               prep_ready;
    logic               prep_valid;
    stage_t             prep_data;

    logic               swap_ready;
    logic               swap_valid;
    stage_t             swap_data;

    logic   [NumCells-1:0] c_in_valid;
    logic   [NumCells-1:0] c_in_ready;
    logic   [NumCells-1:0] c_out_valid;
    logic   [NumCells-1:0] c_down_ready;
    stage_t                c_in_data  [NumCells];
    stage_t                c_out_data [NumCells];

    logic               out_valid_reg;
    logic               out_ready;
    stage_t             last;
    logic [IntW-1:0]    scaled;
    logic               status_reg, status_next;
    logic               frac_en_reg, frac_en_next;
    logic [FracW-1:0]   frac_reg, frac_next;
    logic [IntW-1:0]    int_reg, int_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_clk_reg  <= SysClkReset;
            prescale_reg <= '0;
            half_ovs_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CfgSysClk:   sys_clk_reg  <= cfg_data;
                CfgPrescale: prescale_reg <= cfg_data[1:0];
                CfgHalfOvs:  half_ovs_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign in_stall = !prep_ready;

    ufbd_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (prep_ready),
        .baud_rate  (baud_rate),
        .sys_clk    (sys_clk_reg),
        .prescale   (prescale_reg),
        .half_ovs   (half_ovs_reg),
        .out_valid  (prep_valid),
        .down_ready (c_in_ready[0]),
        .out_data   (prep_data)
    );

    // cell chain wiring: integer cells, turn-around, fraction cells
    always_comb
    begin
        for (int i = 0; i < NumCells; i++)
        begin
            if (i == 0)
            begin
                c_in_valid[i] = prep_valid;
                c_in_data[i]  = prep_data;
            end
            else if (i == NumIntCells)
            begin
                c_in_valid[i] = swap_valid;
                c_in_data[i]  = swap_data;
            end
            else
            begin
                c_in_valid[i] = c_out_valid[i-1];
                c_in_data[i]  = c_out_data[i-1];
            end

            if (i == NumCells - 1)
                c_down_ready[i] = out_ready;
            else if (i == NumIntCells - 1)
                c_down_ready[i] = swap_ready;
            else
                c_down_ready[i] = c_in_ready[i+1];
        end
    end

    for (genvar g = 0; g < NumCells; g++)
    begin : g_cell
        ufbd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (c_in_valid[g]),
            .in_ready   (c_in_ready[g]),
            .in_data    (c_in_data[g]),
            .out_valid  (c_out_valid[g]),
            .down_ready (c_down_ready[g]),
            .out_data   (c_out_data[g])
        );
    end

    ufbd_swap u_swap (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_out_valid[NumIntCells-1]),
        .in_ready   (swap_ready),
        .in_data    (c_out_data[NumIntCells-1]),
        .out_valid  (swap_valid),
        .down_ready (c_in_ready[NumIntCells]),
        .out_data   (swap_data)
    );

    // output register
    assign out_ready = !out_valid_reg || !out_stall;
    assign last      = c_out_data[NumCells-1];
    assign scaled    = last.quo[IntW-1:0];

    always_comb
    begin
        status_next  = 1'b0;
        frac_en_next = 1'b0;
        frac_next    = FracOff;
        int_next     = IntW'(last.qint - QuoW'(1));
        if (last.err || (!last.exact && !scaled[IntW-1]))
        begin
            status_next = 1'b1;
            frac_next   = '0;
            int_next    = '0;
        end
        else if (!last.exact)
        begin
            frac_en_next = 1'b1;
            frac_next    = scaled[FracW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= c_out_valid[NumCells-1];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && c_out_valid[NumCells-1])
        begin
            status_reg  <= status_next;
            frac_en_reg <= frac_en_next;
            frac_reg    <= frac_next;
            int_reg     <= int_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign fraction_enable  = frac_en_reg;
    assign divider_fraction = frac_reg;
    assign divider_integer  = int_reg;

endmodule

### rtl/ufbd_prep.sv
// Entry stage: prescales the clock, forms the baud denominator and the
// integer-divide overflow check. Depends on ufbd_pkg.
module ufbd_prep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ufbd_pkg::BaudW-1:0]   baud_rate,
    input  logic [ufbd_pkg::SysClkW-1:0] sys_clk,
    input  logic [1:0]                   prescale,
    input  logic                         half_ovs,
    output logic                         out_valid,
    input  logic                         down_ready,
    output ufbd_pkg::stage_t             out_data
);
    import ufbd_pkg::*;

    logic                 valid_reg;
    stage_t               data_reg;
    stage_t               data_next;
    logic [SysClkW-1:0]   pclk;
    logic [DenW-1:0]      den;
    logic                 ovf;

    assign in_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        pclk = sys_clk >> {prescale, 1'b0};
        den  = half_ovs ? {1'b0, baud_rate, 3'b000} : {baud_rate, 4'b0000};
        // quotient would reach 512 or more
        ovf  = {8'd0, pclk[SysClkW-1:QuoW]} >= den;

        data_next.rem   = {9'd0, pclk[SysClkW-1:QuoW]};
        data_next.dvs   = {1'b0, den};
        data_next.nbits = pclk[QuoW-1:0];
        data_next.quo   = '0;
        data_next.pclk  = pclk;
        data_next.qint  = '0;
        data_next.err   = (pclk == '0) || (baud_rate == '0) || ovf;
        data_next.exact = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

### rtl/ufbd_cell.sv
// One restoring-division cell: shift in a dividend bit, compare and subtract,
// append one quotient bit. Depends on ufbd_pkg.
module ufbd_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ufbd_pkg::stage_t in_data,
    output logic             out_valid,
    input  logic             down_ready,
    output ufbd_pkg::stage_t out_data
);
    import ufbd_pkg::*;

    logic                 valid_reg;
    stage_t               data_reg;
    stage_t               data_next;
    logic [SysClkW:0]     trial;
    logic                 ge;

    assign in_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        trial = {in_data.rem, in_data.nbits[QuoW-1]};
        ge    = trial >= {1'b0, in_data.dvs};

        data_next       = in_data;
        data_next.rem   = ge ? SysClkW'(trial - {1'b0, in_data.dvs}) : trial[SysClkW-1:0];
        data_next.nbits = {in_data.nbits[QuoW-2:0], 1'b0};
        data_next.quo   = {in_data.quo[QuoW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

### rtl/ufbd_swap.sv
// Turn-around stage between the integer and fraction passes: range checks
// the integer quotient and loads q*den over the clock. Depends on ufbd_pkg.
module ufbd_swap (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ufbd_pkg::stage_t in_data,
    output logic             out_valid,
    input  logic             down_ready,
    output ufbd_pkg::stage_t out_data
);
    import ufbd_pkg::*;

    logic    valid_reg;
    stage_t  data_reg;
    stage_t  data_next;
    logic    q_bad;

    assign in_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        // valid quotient range is 1 to 256
        q_bad = (in_data.quo == '0) || (in_data.quo[QuoW-1] && (in_data.quo[QuoW-2:0] != '0));

        data_next       = in_data;
        data_next.rem   = in_data.pclk - in_data.rem;   // q * den
        data_next.dvs   = in_data.pclk;
        data_next.nbits = '0;
        data_next.quo   = '0;
        data_next.qint  = in_data.quo;
        data_next.err   = in_data.err || q_bad;
        data_next.exact = (in_data.rem == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

### rtl/ufbd_checker.sv
// Port-level checks for the UART fractional baud divider core, and the bind
// that attaches them. Depends on ufbd_pkg and uart_fractional_baud_divider_core.
module ufbd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         status,
    input logic                         fraction_enable,
    input logic [ufbd_pkg::FracW-1:0]   divider_fraction,
    input logic [ufbd_pkg::IntW-1:0]    divider_integer
);
    import ufbd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(divider_integer) && $stable(divider_fraction)
            && $stable(status) && $stable(fraction_enable))
        else $error("out payload changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !fraction_enable && (divider_fraction == '0)
            && (divider_integer == '0))
        else $error("error beat with non-zero fields");

    a_exact_frac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status && !fraction_enable |-> divider_fraction == FracOff)
        else $error("exact divide without fraction field at all ones");

endmodule

bind uart_fractional_baud_divider_core ufbd_checker u_ufbd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .fraction_enable  (fraction_enable),
    .divider_fraction (divider_fraction),
    .divider_integer  (divider_integer)
);

### tb/sv/uart_fractional_baud_divider_core_tb.sv
// Testbench for uart_fractional_baud_divider_core: directed table, then randomised
// baud requests over several clock/prescaler/oversampling settings, checked per beat.
// Depends on ufbd_pkg and the core RTL.
module uart_fractional_baud_divider_core_tb;

    import ufbd_pkg::*;

    typedef struct packed {
        logic             status;
        logic             fraction_enable;
        logic [FracW-1:0] divider_fraction;
        logic [IntW-1:0]  divider_integer;
    } divider_t;

    typedef struct packed {
        bit                  is_cfg;
        logic [CfgIdxW-1:0]  idx;
        logic [SysClkW-1:0]  value;
        bit                  typed;
        divider_t            want;
    } step_t;

    localparam logic [CfgIdxW-1:0] CfgSpare  = 2'd3;
    localparam logic [SysClkW-1:0] SysClkMax = 29'h1FFF_FFFF;
    localparam logic [BaudW-1:0]   BaudMax   = 24'hFF_FFFF;
    localparam divider_t ErrResult = '{1'b1, 1'b0, 7'd0, 8'd0};
    localparam divider_t NoCheck   = '{1'b0, 1'b0, 7'd0, 8'd0};
    localparam int NumPhases     = 10;
    localparam int BeatsPerPhase = 75;
    localparam int HoldCycles    = 150;
    localparam int NumSteps      = 26;

    localparam step_t DirectedSteps [NumSteps] = '{
        '{1'b0, CfgSysClk,   29'd0,        1'b1, ErrResult},
        '{1'b0, CfgSysClk,   29'd16777215, 1'b1, ErrResult},
        '{1'b0, CfgSysClk,   29'd500000,   1'b1, '{1'b0, 1'b0, FracOff, 8'd0}},
        '{1'b0, CfgSysClk,   29'd250000,   1'b1, '{1'b0, 1'b0, FracOff, 8'd1}},
        '{1'b0, CfgSysClk,   29'd31250,    1'b1, '{1'b0, 1'b0, FracOff, 8'd15}},
        '{1'b0, CfgSysClk,   29'd1953,     1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd1900,     1'b1, ErrResult},
        '{1'b0, CfgSysClk,   29'd115200,   1'b0, NoCheck},
        '{1'b1, CfgHalfOvs,  29'd1,        1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd1000000,  1'b1, '{1'b0, 1'b0, FracOff, 8'd0}},
        '{1'b0, CfgSysClk,   29'd9600,     1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd3907,     1'b0, NoCheck},
        '{1'b1, CfgSysClk,   SysClkMax,    1'b0, NoCheck},
        '{1'b1, CfgPrescale, 29'd3,        1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd1,        1'b1, ErrResult},
        '{1'b0, CfgSysClk,   29'd38400,    1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd16777215, 1'b1, ErrResult},
        '{1'b1, CfgSysClk,   29'd3,        1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd1,        1'b1, ErrResult},
        '{1'b1, CfgPrescale, 29'd0,        1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd1,        1'b1, ErrResult},
        '{1'b1, CfgSysClk,   29'd0,        1'b0, NoCheck},
        '{1'b0, CfgSysClk,   29'd1,        1'b1, ErrResult},
        '{1'b1, CfgSpare,    29'h1555_5555, 1'b0, NoCheck},
        '{1'b1, CfgSysClk,   SysClkReset,  1'b0, NoCheck},
        '{1'b1, CfgHalfOvs,  29'd0,        1'b0, NoCheck}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [CfgIdxW-1:0] cfg_index;
    logic [SysClkW-1:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [BaudW-1:0]   baud_rate;
    logic               out_valid;
    logic               out_stall;
    logic               status;
    logic               fraction_enable;
    logic [FracW-1:0]   divider_fraction;
    logic [IntW-1:0]    divider_integer;

    logic [SysClkW-1:0] sys_clk_hz;
    logic [1:0]         prescale;
    logic               half_ovs;

    divider_t    pending_dividers [$];
    int          mismatches = 0;
    bit          hold_req = 1'b0;
    bit          no_idle = 1'b0;
    logic [BaudW-1:0] spot_baud = 24'd1;

    uart_fractional_baud_divider_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .baud_rate        (baud_rate),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .fraction_enable  (fraction_enable),
        .divider_fraction (divider_fraction),
        .divider_integer  (divider_integer)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic divider_t calc_divider(input logic [BaudW-1:0] baud);
        longint unsigned b, mult, pclk, den, q, r, scaled;
        divider_t res;
        res    = ErrResult;
        b      = baud;
        mult   = 2 - longint'(half_ovs);
        pclk   = longint'(sys_clk_hz) >> (2 * prescale);
        den    = b * 8 * mult;
        if (pclk == 0 || den == 0)
            return res;
        q = pclk / den;
        r = pclk % den;
        if (q == 0 || q - 1 > 255)
            return res;
        if (r == 0)
        begin
            res = '{1'b0, 1'b0, 7'h7F, IntW'(q - 1)};
            return res;
        end
        scaled = (2048 * mult * q * b) / pclk;
        if (scaled < 128 || scaled - 128 > 127)
            return res;
        res = '{1'b0, 1'b1, FracW'(scaled - 128), IntW'(q - 1)};
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BaudW-1:0] pick_baud();
        longint unsigned pclk, ovs, q, t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return BaudW'($urandom);
        if (r < 15)
            return BaudW'($urandom_range(0, 2000));
        if (r < 25)
            return spot_baud;
        pclk = longint'(sys_clk_hz) >> (2 * prescale);
        ovs  = half_ovs ? 8 : 16;
        q    = $urandom_range(1, 262);
        t    = pclk / (ovs * q) + $urandom_range(0, 2);
        t    = (t == 0) ? 0 : t - 1;
        if (t > BaudMax)
            t = BaudMax;
        return BaudW'(t);
    endfunction

    task automatic log_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
        mismatches++;
        $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SysClkW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CfgSysClk:   sys_clk_hz = data;
            CfgPrescale: prescale   = data[1:0];
            CfgHalfOvs:  half_ovs   = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_dividers.size() == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_baud(input logic [BaudW-1:0] b, input bit typed, input divider_t want);
        int gap;
        gap = (no_idle || hold_req) ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid  <= 1'b0;
            baud_rate <= BaudW'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        baud_rate <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_dividers.push_back(typed ? want : calc_divider(b));
    endtask

    // Receiver: random stalls, or one long hold-off on request
    initial
    begin : receiver
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = no_idle ? 0 : idle_len();
                if (n != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        divider_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dividers.size() == 0)
                log_mismatch("beat with nothing pending", divider_integer, 0);
            else
            begin
                want = pending_dividers.pop_front();
                if (status !== want.status)
                    log_mismatch("status", status, want.status);
                if (fraction_enable !== want.fraction_enable)
                    log_mismatch("fraction_enable", fraction_enable, want.fraction_enable);
                if (divider_fraction !== want.divider_fraction)
                    log_mismatch("divider_fraction", divider_fraction, want.divider_fraction);
                if (divider_integer !== want.divider_integer)
                    log_mismatch("divider_integer", divider_integer, want.divider_integer);
            end
        end
    end

    initial
    begin : stimulus
        logic [SysClkW-1:0] sys, data;
        logic [1:0]         psc;
        logic               ovs;
        longint unsigned    prod, ovsf;
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= CfgSysClk;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        baud_rate  <= '0;
        sys_clk_hz = SysClkReset;
        prescale   = 2'd0;
        half_ovs   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DirectedSteps[i])
        begin
            if (DirectedSteps[i].is_cfg)
            begin
                drain();
                write_reg(DirectedSteps[i].idx, DirectedSteps[i].value);
            end
            else
                send_baud(DirectedSteps[i].value[BaudW-1:0], DirectedSteps[i].typed,
                          DirectedSteps[i].want);
        end

        for (int phase = 0; phase < NumPhases; phase++)
        begin
            drain();
            psc = 2'($urandom_range(0, 3));
            ovs = 1'($urandom_range(0, 1));
            case (phase)
                0:
                begin
                    sys = SysClkMax;
                    psc = 2'd3;
                    ovs = 1'b1;
                end
                1:
                begin
                    sys = SysClkMax;
                    psc = 2'd0;
                    ovs = 1'b0;
                end
                2:  sys = SysClkW'($urandom_range(1, 64));
                default:
                begin
                    if (phase % 2 == 1)
                        sys = SysClkW'($urandom);
                    else
                    begin
                        // clock an exact multiple of the spot rate
                        ovsf      = ovs ? 8 : 16;
                        spot_baud = BaudW'($urandom_range(1, 5000));
                        prod      = ovsf * spot_baud * $urandom_range(1, 256);
                        if ((prod << (2 * psc)) > SysClkMax)
                            psc = 2'd0;
                        sys = SysClkW'(prod << (2 * psc));
                    end
                end
            endcase
            write_reg(CfgSysClk, sys);
            data      = SysClkW'($urandom);
            data[1:0] = psc;
            write_reg(CfgPrescale, data);
            data      = SysClkW'($urandom);
            data[0]   = ovs;
            write_reg(CfgHalfOvs, data);
            if ($urandom_range(0, 2) == 0)
                write_reg(CfgSpare, SysClkW'($urandom));
            if (phase % 2 == 1 || phase < 3)
                spot_baud = BaudW'((longint'(sys_clk_hz) >> (2 * prescale))
                                   / ((half_ovs ? 8 : 16) * $urandom_range(1, 256)));
            no_idle = (phase % 4 == 1);

            for (int n = 0; n < BeatsPerPhase; n++)
            begin
                if ((phase == 3 || phase == 7) && n == 15)
                    hold_req = 1'b1;
                if (phase % 2 == 0 && n == 40)
                    drain();
                send_baud(pick_baud(), 1'b0, NoCheck);
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
